// File: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// assert_macros.svh
// shared assertion macros, clocked on clk and disabled while rst_n is low
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define PQU_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// expression must never be true at a clock edge out of reset
`define PQU_ASSERT_NEVER(lbl, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error(msg);

`endif

// File: hdl/pqu_pkg.sv
// ---------------------------------------------------------------------------
// pqu_pkg
// shared types and constants of the plane query unit
// ---------------------------------------------------------------------------
package pqu_pkg;

    localparam int FRAC_BITS_DEF   = 16;
    localparam int COORD_WIDTH_DEF = 32;

    localparam int NORM_WIDTH      = 18;
    localparam int OFFSET_WIDTH    = 32;
    localparam int CFG_DATA_WIDTH  = 32;
    localparam int CFG_INDEX_WIDTH = 2;

    // cross product components are clamped to +-2^20
    localparam int CROSS_WIDTH     = 22;
    localparam int CROSS_MAG_WIDTH = 21;
    localparam logic signed [CROSS_WIDTH-1:0] CROSS_CLAMP = 22'sd1048576;

    // cycles from accepted start to done
    localparam int LATENCY = 5;

    localparam logic signed [NORM_WIDTH-1:0]   NORMAL_X_RST = 18'sd0;
    localparam logic signed [NORM_WIDTH-1:0]   NORMAL_Y_RST = 18'sd0;
    localparam logic signed [NORM_WIDTH-1:0]   NORMAL_Z_RST = 18'sd65536;
    localparam logic signed [OFFSET_WIDTH-1:0] OFFSET_RST   = 32'sd0;

    typedef enum logic [1:0] {
        FUNC_TRIANGLE = 2'd0,
        FUNC_PLANE    = 2'd1,
        FUNC_POINT    = 2'd2,
        FUNC_NEAREST  = 2'd3
    } func_t;

    typedef enum logic [CFG_INDEX_WIDTH-1:0] {
        REG_NORMAL_X     = 2'd0,
        REG_NORMAL_Y     = 2'd1,
        REG_NORMAL_Z     = 2'd2,
        REG_PLANE_OFFSET = 2'd3
    } cfg_index_t;

    // per-lane distance status handed to the merge stage
    typedef struct packed {
        logic neg;
        logic zero;
        logic touch;
    } dist_flags_t;

endpackage

// File: hdl/pqu_dist_lane.sv
// ---------------------------------------------------------------------------
// pqu_dist_lane
// signed plane distance of one point, three-stage pipeline
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pqu_dist_lane
    import pqu_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    localparam int MAG_WIDTH  = 2 * FRAC_BITS - 8
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic signed [COORD_WIDTH-1:0]  x,
    input  logic signed [COORD_WIDTH-1:0]  y,
    input  logic signed [COORD_WIDTH-1:0]  z,
    input  logic signed [NORM_WIDTH-1:0]   nx,
    input  logic signed [NORM_WIDTH-1:0]   ny,
    input  logic signed [NORM_WIDTH-1:0]   nz,
    input  logic signed [OFFSET_WIDTH-1:0] offset,
    output logic [MAG_WIDTH-1:0]           mag,
    output dist_flags_t                    flags,
    output logic signed [COORD_WIDTH-1:0]  distance
);

    localparam int PW  = COORD_WIDTH + NORM_WIDTH;
    localparam int DW0 = (PW > OFFSET_WIDTH + FRAC_BITS) ? PW : OFFSET_WIDTH + FRAC_BITS;
    localparam int DW1 = (DW0 > COORD_WIDTH + FRAC_BITS) ? DW0 : COORD_WIDTH + FRAC_BITS;
    localparam int DW  = DW1 + 2;
    localparam int TOP = FRAC_BITS + COORD_WIDTH - 1;
    localparam logic [63:0] TOUCH_THR = ((64'd1 << (2 * FRAC_BITS)) + 64'd500) / 64'd1000;
    localparam logic signed [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic signed [PW-1:0]          px_reg;
    logic signed [PW-1:0]          py_reg;
    logic signed [PW-1:0]          pz_reg;
    logic signed [DW-1:0]          sum_reg;
    logic signed [DW-1:0]          off_ext;
    logic [DW-1:0]                 mag_full;
    logic                          touch;
    logic                          fits;
    logic [MAG_WIDTH-1:0]          mag_reg;
    dist_flags_t                   flags_reg;
    logic signed [COORD_WIDTH-1:0] dist_reg;

    // exact distance in Q.(2*FRAC_BITS)
    assign off_ext = DW'(offset) <<< FRAC_BITS;

    always_comb
    begin
        mag_full = sum_reg[DW-1] ? DW'(-sum_reg) : DW'(sum_reg);
        touch    = (mag_full < TOUCH_THR);
        fits     = (&sum_reg[DW-1:TOP]) || (~|sum_reg[DW-1:TOP]);
    end

    always_ff @(posedge clk)
    begin
        px_reg  <= x * nx;
        py_reg  <= y * ny;
        pz_reg  <= z * nz;
        sum_reg <= DW'(px_reg) + DW'(py_reg) + DW'(pz_reg) - off_ext;

        // magnitude clamped at the threshold, sums of three stay narrow
        mag_reg         <= touch ? mag_full[MAG_WIDTH-1:0] : MAG_WIDTH'(TOUCH_THR);
        flags_reg.neg   <= sum_reg[DW-1];
        flags_reg.zero  <= (sum_reg == '0);
        flags_reg.touch <= touch;
        if (fits)
        begin
            dist_reg <= sum_reg[TOP:FRAC_BITS];
        end
        else
        begin
            dist_reg <= sum_reg[DW-1] ? SAT_MIN : SAT_MAX;
        end
    end

    assign mag      = mag_reg;
    assign flags    = flags_reg;
    assign distance = dist_reg;

    `PQU_ASSERT(a_zero_touches, (flags_reg.zero |-> (flags_reg.touch && !flags_reg.neg)), "zero distance not flagged as contact")

endmodule

// File: hdl/pqu_cross_lane.sv
// ---------------------------------------------------------------------------
// pqu_cross_lane
// parallel test of a second normal against the plane normal, four stages
// ---------------------------------------------------------------------------
module pqu_cross_lane
    import pqu_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic signed [COORD_WIDTH-1:0] ax,
    input  logic signed [COORD_WIDTH-1:0] ay,
    input  logic signed [COORD_WIDTH-1:0] az,
    input  logic signed [NORM_WIDTH-1:0]  nx,
    input  logic signed [NORM_WIDTH-1:0]  ny,
    input  logic signed [NORM_WIDTH-1:0]  nz,
    output logic                          par_hit
);

    localparam int PW    = COORD_WIDTH + NORM_WIDTH;
    localparam int DFW   = (PW + 1 > CROSS_WIDTH) ? PW + 1 : CROSS_WIDTH;
    localparam int SQ_W  = 2 * CROSS_MAG_WIDTH;
    localparam int SUM_W = SQ_W + 2;
    localparam logic [63:0] PAR_THR = ((64'd1 << (2 * FRAC_BITS)) + 64'd5000) / 64'd10000;
    localparam logic signed [DFW-1:0] CLP_POS = DFW'(CROSS_CLAMP);
    localparam logic signed [DFW-1:0] CLP_NEG = -CLP_POS;

    logic signed [PW-1:0]          p_reg [3];
    logic signed [PW-1:0]          q_reg [3];
    logic signed [CROSS_WIDTH-1:0] c_reg [3];
    logic [SQ_W-1:0]               sq_reg [3];
    logic                          par_hit_reg;

    logic signed [DFW-1:0]         diff [3];
    logic signed [DFW-1:0]         shf [3];
    logic signed [CROSS_WIDTH-1:0] c_next [3];
    logic signed [CROSS_WIDTH-1:0] cneg [3];
    logic [CROSS_MAG_WIDTH-1:0]    cabs [3];

    // floor to Q.FRAC_BITS then clamp, one component per element
    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            diff[i] = DFW'(p_reg[i]) - DFW'(q_reg[i]);
            shf[i]  = diff[i] >>> FRAC_BITS;
            if (shf[i] > CLP_POS)
            begin
                c_next[i] = CROSS_CLAMP;
            end
            else if (shf[i] < CLP_NEG)
            begin
                c_next[i] = -CROSS_CLAMP;
            end
            else
            begin
                c_next[i] = shf[i][CROSS_WIDTH-1:0];
            end
            cneg[i] = -c_reg[i];
            cabs[i] = c_reg[i][CROSS_WIDTH-1] ? cneg[i][CROSS_MAG_WIDTH-1:0]
                                              : c_reg[i][CROSS_MAG_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        // (ax,ay,az) x n
        p_reg[0] <= ay * nz;
        q_reg[0] <= az * ny;
        p_reg[1] <= az * nx;
        q_reg[1] <= ax * nz;
        p_reg[2] <= ax * ny;
        q_reg[2] <= ay * nx;
        for (int i = 0; i < 3; i++)
        begin
            c_reg[i]  <= c_next[i];
            sq_reg[i] <= SQ_W'(cabs[i]) * SQ_W'(cabs[i]);
        end
        par_hit_reg <= (SUM_W'(sq_reg[0]) + SUM_W'(sq_reg[1]) + SUM_W'(sq_reg[2])) > PAR_THR;
    end

    assign par_hit = par_hit_reg;

endmodule

// File: hdl/pqu_proj_lane.sv
// ---------------------------------------------------------------------------
// pqu_proj_lane
// projection of one coordinate onto the plane, saturated
// ---------------------------------------------------------------------------
module pqu_proj_lane
    import pqu_pkg::*;
#(
    parameter int COORD_WIDTH = COORD_WIDTH_DEF,
    parameter int FRAC_BITS   = FRAC_BITS_DEF
)
(
    input  logic                          clk,
    input  logic signed [COORD_WIDTH-1:0] p,
    input  logic signed [COORD_WIDTH-1:0] fd,
    input  logic signed [NORM_WIDTH-1:0]  n,
    output logic signed [COORD_WIDTH-1:0] near
);

    localparam int PW    = COORD_WIDTH + NORM_WIDTH;
    localparam int EW0   = (COORD_WIDTH > PW - FRAC_BITS) ? COORD_WIDTH : PW - FRAC_BITS;
    localparam int EW    = EW0 + 1;
    localparam int DELAY = LATENCY - 1;
    localparam logic signed [COORD_WIDTH-1:0] SAT_MAX = {1'b0, {(COORD_WIDTH-1){1'b1}}};
    localparam logic signed [COORD_WIDTH-1:0] SAT_MIN = {1'b1, {(COORD_WIDTH-1){1'b0}}};

    logic signed [COORD_WIDTH-1:0] p_pipe_reg [DELAY];
    logic signed [PW-1:0]          prod_reg;
    logic signed [COORD_WIDTH-1:0] near_reg;
    logic signed [EW-1:0]          diff;
    logic                          fits;

    always_comb
    begin
        diff = EW'(p_pipe_reg[DELAY-1]) - EW'(prod_reg >>> FRAC_BITS);
        fits = (&diff[EW-1:COORD_WIDTH-1]) || (~|diff[EW-1:COORD_WIDTH-1]);
    end

    always_ff @(posedge clk)
    begin
        p_pipe_reg[0] <= p;
        for (int i = 1; i < DELAY; i++)
        begin
            p_pipe_reg[i] <= p_pipe_reg[i-1];
        end
        prod_reg <= fd * n;
        if (fits)
        begin
            near_reg <= diff[COORD_WIDTH-1:0];
        end
        else
        begin
            near_reg <= diff[EW-1] ? SAT_MIN : SAT_MAX;
        end
    end

    assign near = near_reg;

endmodule

// File: hdl/pqu_merge.sv
// ---------------------------------------------------------------------------
// pqu_merge
// combines lane findings into the hit flag of the selected query
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module pqu_merge
    import pqu_pkg::*;
#(
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    localparam int MAG_WIDTH = 2 * FRAC_BITS - 8
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  func_t                func,
    input  logic [MAG_WIDTH-1:0] mag_a,
    input  logic [MAG_WIDTH-1:0] mag_b,
    input  logic [MAG_WIDTH-1:0] mag_c,
    input  dist_flags_t          flags_a,
    input  dist_flags_t          flags_b,
    input  dist_flags_t          flags_c,
    input  logic                 par_hit,
    output logic                 hit
);

    localparam logic [63:0] TOUCH_THR = ((64'd1 << (2 * FRAC_BITS)) + 64'd500) / 64'd1000;

    logic [MAG_WIDTH+1:0] mag_sum;
    logic                 sign_split;
    logic                 tri_hit_reg;
    logic                 pt_hit_reg;
    func_t                func_reg;
    logic                 hit_reg;
    logic                 hit_next;

    always_comb
    begin
        mag_sum    = (MAG_WIDTH+2)'(mag_a) + (MAG_WIDTH+2)'(mag_b) + (MAG_WIDTH+2)'(mag_c);
        sign_split = !((flags_a.neg == flags_b.neg) && (flags_a.zero == flags_b.zero) &&
                       (flags_b.neg == flags_c.neg) && (flags_b.zero == flags_c.zero));
    end

    always_comb
    begin
        case (func_reg)
            FUNC_TRIANGLE: hit_next = tri_hit_reg;
            FUNC_PLANE:    hit_next = par_hit;
            FUNC_POINT:    hit_next = pt_hit_reg;
            FUNC_NEAREST:  hit_next = 1'b0;
            default:       hit_next = 1'b0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        tri_hit_reg <= (mag_sum < TOUCH_THR) || sign_split;
        pt_hit_reg  <= flags_a.touch;
        func_reg    <= func;
        hit_reg     <= hit_next;
    end

    assign hit = hit_reg;

    `PQU_ASSERT(a_nearest_no_hit, ((func_reg == FUNC_NEAREST) |=> !hit_reg), "nearest query reported a hit")

endmodule

// File: hdl/plane_query_unit_top.sv
// ---------------------------------------------------------------------------
// plane_query_unit_top
// geometry queries against one configured plane, Q.FRAC_BITS fixed point
// ---------------------------------------------------------------------------
// usage
//   configuration: cfg_we writes cfg_data into register cfg_index (normal x,
//   normal y, normal z, plane offset) at the clock edge; write only while no
//   query is in flight
//   command: a query transfer happens at a clock edge with start high and
//   busy low; busy stays low, so a new query may be issued every cycle
//   result: done is high for exactly one cycle, once the start transfer has
//   passed the valid pipeline, with hit, near_x/y/z and first_distance valid in
//   that cycle; the result transfer completes at the edge that ends the cycle
//   throughput: one query per cycle; each query passes through the multiply /
//   add / clamp stages of the distance and projection lanes
//   the receiver has no way to stall; results must be captured when done
//   reset: async active-low rst_n empties the pipeline (no done pulses) and
//   loads the default plane z = 0 (normal +z, offset 0)
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module plane_query_unit_top
    import pqu_pkg::*;
#(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration write port
    input  logic                          cfg_we,
    input  logic [CFG_INDEX_WIDTH-1:0]    cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]     cfg_data,
    // command
    input  logic                          start,
    output logic                          busy,
    input  logic [1:0]                    func,
    input  logic signed [COORD_WIDTH-1:0] ax,
    input  logic signed [COORD_WIDTH-1:0] ay,
    input  logic signed [COORD_WIDTH-1:0] az,
    input  logic signed [COORD_WIDTH-1:0] bx,
    input  logic signed [COORD_WIDTH-1:0] by,
    input  logic signed [COORD_WIDTH-1:0] bz,
    input  logic signed [COORD_WIDTH-1:0] cx,
    input  logic signed [COORD_WIDTH-1:0] cy,
    input  logic signed [COORD_WIDTH-1:0] cz,
    // result
    output logic                          done,
    output logic                          hit,
    output logic signed [COORD_WIDTH-1:0] near_x,
    output logic signed [COORD_WIDTH-1:0] near_y,
    output logic signed [COORD_WIDTH-1:0] near_z,
    output logic signed [COORD_WIDTH-1:0] first_distance
);

    localparam int MAG_WIDTH = 2 * FRAC_BITS - 8;
    localparam int FUNC_DEPTH = 3;

    // plane registers
    logic signed [NORM_WIDTH-1:0]   normal_x_reg, normal_x_next;
    logic signed [NORM_WIDTH-1:0]   normal_y_reg, normal_y_next;
    logic signed [NORM_WIDTH-1:0]   normal_z_reg, normal_z_next;
    logic signed [OFFSET_WIDTH-1:0] plane_offset_reg, plane_offset_next;

    // pipeline control
    logic                 accept;
    logic [LATENCY-1:0]   valid_reg, valid_next;
    func_t                func_pipe_reg [FUNC_DEPTH];

    // lane results
    logic [MAG_WIDTH-1:0]          mag_a, mag_b, mag_c;
    dist_flags_t                   flags_a, flags_b, flags_c;
    logic signed [COORD_WIDTH-1:0] dist_a, dist_b, dist_c;
    logic                          par_hit;
    logic signed [COORD_WIDTH-1:0] fd4_reg;
    logic signed [COORD_WIDTH-1:0] fd5_reg;

    // every cycle can take a query: the pipeline never backs up
    assign busy   = 1'b0;
    assign accept = start && !busy;

    // configuration decode
    always_comb
    begin
        normal_x_next     = normal_x_reg;
        normal_y_next     = normal_y_reg;
        normal_z_next     = normal_z_reg;
        plane_offset_next = plane_offset_reg;
        if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                REG_NORMAL_X:     normal_x_next     = cfg_data[NORM_WIDTH-1:0];
                REG_NORMAL_Y:     normal_y_next     = cfg_data[NORM_WIDTH-1:0];
                REG_NORMAL_Z:     normal_z_next     = cfg_data[NORM_WIDTH-1:0];
                REG_PLANE_OFFSET: plane_offset_next = cfg_data[OFFSET_WIDTH-1:0];
                default:          normal_x_next     = normal_x_reg;
            endcase
        end
    end

    // valid bits shift one stage per cycle, no stall path
    assign valid_next = {valid_reg[LATENCY-2:0], accept};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            normal_x_reg     <= NORMAL_X_RST;
            normal_y_reg     <= NORMAL_Y_RST;
            normal_z_reg     <= NORMAL_Z_RST;
            plane_offset_reg <= OFFSET_RST;
            valid_reg        <= '0;
        end
        else
        begin
            normal_x_reg     <= normal_x_next;
            normal_y_reg     <= normal_y_next;
            normal_z_reg     <= normal_z_next;
            plane_offset_reg <= plane_offset_next;
            valid_reg        <= valid_next;
        end
    end

    // query code follows the distance lanes to the merge stage
    always_ff @(posedge clk)
    begin
        func_pipe_reg[0] <= func_t'(func);
        for (int i = 1; i < FUNC_DEPTH; i++)
        begin
            func_pipe_reg[i] <= func_pipe_reg[i-1];
        end
        fd4_reg <= dist_a;
        fd5_reg <= fd4_reg;
    end

    // three distance lanes, one per vertex; lane a also serves point queries
    pqu_dist_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dist_a (
        .clk      (clk),
        .rst_n    (rst_n),
        .x        (ax),
        .y        (ay),
        .z        (az),
        .nx       (normal_x_reg),
        .ny       (normal_y_reg),
        .nz       (normal_z_reg),
        .offset   (plane_offset_reg),
        .mag      (mag_a),
        .flags    (flags_a),
        .distance (dist_a)
    );

    pqu_dist_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dist_b (
        .clk      (clk),
        .rst_n    (rst_n),
        .x        (bx),
        .y        (by),
        .z        (bz),
        .nx       (normal_x_reg),
        .ny       (normal_y_reg),
        .nz       (normal_z_reg),
        .offset   (plane_offset_reg),
        .mag      (mag_b),
        .flags    (flags_b),
        .distance (dist_b)
    );

    pqu_dist_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_dist_c (
        .clk      (clk),
        .rst_n    (rst_n),
        .x        (cx),
        .y        (cy),
        .z        (cz),
        .nx       (normal_x_reg),
        .ny       (normal_y_reg),
        .nz       (normal_z_reg),
        .offset   (plane_offset_reg),
        .mag      (mag_c),
        .flags    (flags_c),
        .distance (dist_c)
    );

    // plane-vs-plane lane, result lines up with the merge stage
    pqu_cross_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_cross (
        .clk     (clk),
        .ax      (ax),
        .ay      (ay),
        .az      (az),
        .nx      (normal_x_reg),
        .ny      (normal_y_reg),
        .nz      (normal_z_reg),
        .par_hit (par_hit)
    );

    // projection lanes take the saturated first distance from lane a
    pqu_proj_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_proj_x (
        .clk  (clk),
        .p    (ax),
        .fd   (dist_a),
        .n    (normal_x_reg),
        .near (near_x)
    );

    pqu_proj_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_proj_y (
        .clk  (clk),
        .p    (ay),
        .fd   (dist_a),
        .n    (normal_y_reg),
        .near (near_y)
    );

    pqu_proj_lane #(.COORD_WIDTH(COORD_WIDTH), .FRAC_BITS(FRAC_BITS)) u_proj_z (
        .clk  (clk),
        .p    (az),
        .fd   (dist_a),
        .n    (normal_z_reg),
        .near (near_z)
    );

    pqu_merge #(.FRAC_BITS(FRAC_BITS)) u_merge (
        .clk     (clk),
        .rst_n   (rst_n),
        .func    (func_pipe_reg[FUNC_DEPTH-1]),
        .mag_a   (mag_a),
        .mag_b   (mag_b),
        .mag_c   (mag_c),
        .flags_a (flags_a),
        .flags_b (flags_b),
        .flags_c (flags_c),
        .par_hit (par_hit),
        .hit     (hit)
    );

    assign done           = valid_reg[LATENCY-1];
    assign first_distance = fd5_reg;

    // b and c distances only feed the triangle test; their values are unused
    logic unused_dist;
    assign unused_dist = ^{dist_b, dist_c};

    `PQU_ASSERT(a_start_gives_done, (accept |-> ##5 done), "query transfer without result five cycles later")
    `PQU_ASSERT(a_done_has_start, (done |-> $past(accept, 5)), "result without matching query transfer")

endmodule

// File: sim/tb_plane_query_unit_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_plane_query_unit_top
// self-checking bench: random and directed triangle, plane, point and
// nearest-point queries against several plane settings, each result
// checked field by field against an in-bench fixed-point predictor
// ---------------------------------------------------------------------------
module tb_plane_query_unit_top;
    import pqu_pkg::*;

    localparam int CLK_PERIOD = 20;
    localparam int FRAC       = FRAC_BITS_DEF;
    localparam int CW         = COORD_WIDTH_DEF;

    localparam int TIMEOUT_NS   = 5_000_000;
    localparam int IDLE_GUARD   = 20_000;
    localparam int PHASES       = 12;
    localparam int PHASE_ITEMS  = 160;
    localparam int REPORT_LIMIT = 10;

    typedef logic signed [CW-1:0] coord_t;

    localparam coord_t COORD_HI = 32'sh7FFF_FFFF;
    localparam coord_t COORD_LO = 32'sh8000_0000;
    localparam coord_t ONE      = 32'sd65536;

    // contact and parallel thresholds in Q.(2*FRAC)
    localparam longint TOUCH_LIMIT    = ((64'sd1 <<< (2 * FRAC)) + 500) / 1000;
    localparam longint PARALLEL_LIMIT = ((64'sd1 <<< (2 * FRAC)) + 5000) / 10000;
    localparam longint CROSS_LIMIT    = 64'sd1 <<< 20;

    typedef struct {
        func_t  func;
        coord_t ax, ay, az;
        coord_t bx, by, bz;
        coord_t cx, cy, cz;
    } query_t;

    typedef struct {
        logic   hit;
        coord_t near_x, near_y, near_z;
        coord_t distance;
    } plane_answer_t;

    // ------------------------------------------------------------------
    // dut signals, all inputs known from time zero
    // ------------------------------------------------------------------
    logic                       clk;
    logic                       rst_n     = 1'b0;
    logic                       cfg_we    = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0] cfg_index = '0;
    logic [CFG_DATA_WIDTH-1:0]  cfg_data  = '0;
    logic                       start     = 1'b0;
    logic                       busy;
    logic [1:0]                 func      = '0;
    coord_t ax = '0, ay = '0, az = '0;
    coord_t bx = '0, by = '0, bz = '0;
    coord_t cx = '0, cy = '0, cz = '0;
    logic                       done;
    logic                       hit;
    coord_t                     near_x, near_y, near_z, first_distance;

    // plane as the bench believes it is programmed
    longint norm_x    = longint'(NORMAL_X_RST);
    longint norm_y    = longint'(NORMAL_Y_RST);
    longint norm_z    = longint'(NORMAL_Z_RST);
    longint plane_ofs = longint'(OFFSET_RST);

    query_t        query_backlog[$];
    plane_answer_t expected_answers[$];
    query_t        drive_q;
    plane_answer_t want;
    int            idle_pct       = 30;
    int            mismatch_count = 0;

    plane_query_unit_top u_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .start          (start),
        .busy           (busy),
        .func           (func),
        .ax             (ax),
        .ay             (ay),
        .az             (az),
        .bx             (bx),
        .by             (by),
        .bz             (bz),
        .cx             (cx),
        .cy             (cy),
        .cz             (cz),
        .done           (done),
        .hit            (hit),
        .near_x         (near_x),
        .near_y         (near_y),
        .near_z         (near_z),
        .first_distance (first_distance)
    );

    // ------------------------------------------------------------------
    // fixed-point predictor
    // ------------------------------------------------------------------

    // saturate to the coordinate width
    function automatic coord_t clip_coord(longint v);
        if (v > longint'(COORD_HI))
            return COORD_HI;
        if (v < longint'(COORD_LO))
            return COORD_LO;
        return coord_t'(v);
    endfunction

    // exact signed distance in Q.(2*FRAC), fits easily in 64 bits
    function automatic longint plane_dist(coord_t x, coord_t y, coord_t z);
        return longint'(x) * norm_x + longint'(y) * norm_y + longint'(z) * norm_z
            - plane_ofs * (64'sd1 <<< FRAC);
    endfunction

    // one cross product component, floored to Q.FRAC and clamped to +-2^20
    function automatic longint cross_term(coord_t p, longint np, coord_t q, longint nq);
        longint s;
        s = (longint'(p) * np - longint'(q) * nq) >>> FRAC;
        if (s > CROSS_LIMIT)
            return CROSS_LIMIT;
        if (s < -CROSS_LIMIT)
            return -CROSS_LIMIT;
        return s;
    endfunction

    function automatic coord_t project_axis(coord_t p, coord_t d, longint n);
        return clip_coord(longint'(p) - ((longint'(d) * n) >>> FRAC));
    endfunction

    function automatic int sign_of(longint v);
        return (v < 0) ? -1 : ((v == 0) ? 0 : 1);
    endfunction

    function automatic longint mag(longint v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic plane_answer_t plane_answer(query_t q);
        longint        da, db, dc;
        longint        c0, c1, c2;
        coord_t        fd;
        plane_answer_t r;
        da = plane_dist(q.ax, q.ay, q.az);
        fd = clip_coord(da >>> FRAC);
        r.hit = 1'b0;
        case (q.func)
            FUNC_TRIANGLE:
            begin
                db = plane_dist(q.bx, q.by, q.bz);
                dc = plane_dist(q.cx, q.cy, q.cz);
                if (mag(da) + mag(db) + mag(dc) < TOUCH_LIMIT)
                    r.hit = 1'b1;
                else if (!(sign_of(da) == sign_of(db) && sign_of(db) == sign_of(dc)))
                    r.hit = 1'b1;
            end
            FUNC_PLANE:
            begin
                c0 = cross_term(q.ay, norm_z, q.az, norm_y);
                c1 = cross_term(q.az, norm_x, q.ax, norm_z);
                c2 = cross_term(q.ax, norm_y, q.ay, norm_x);
                r.hit = (c0 * c0 + c1 * c1 + c2 * c2) > PARALLEL_LIMIT;
            end
            FUNC_POINT:
                r.hit = mag(da) < TOUCH_LIMIT;
            default:
                r.hit = 1'b0;
        endcase
        r.near_x   = project_axis(q.ax, fd, norm_x);
        r.near_y   = project_axis(q.ay, fd, norm_y);
        r.near_z   = project_axis(q.az, fd, norm_z);
        r.distance = fd;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // random stimulus helpers
    // ------------------------------------------------------------------
    function automatic int jitter(int span);
        return int'($urandom_range(2 * span)) - span;
    endfunction

    // mostly small coordinates (+-16.0), some full range and corner values
    function automatic coord_t rand_coord();
        case ($urandom_range(9))
            0: return coord_t'($urandom());
            1:
            begin
                case ($urandom_range(3))
                    0: return COORD_HI;
                    1: return COORD_LO;
                    2: return '0;
                    default: return '1;
                endcase
            end
            default: return coord_t'(int'($urandom_range(2097152)) - 1048576);
        endcase
    endfunction

    // a vertex, often snapped onto the plane and nudged so that the
    // contact threshold and the sign tests are both exercised
    function automatic void random_vertex(output coord_t x, output coord_t y,
                                          output coord_t z);
        query_t        probe;
        plane_answer_t spot;
        x = rand_coord();
        y = rand_coord();
        z = rand_coord();
        if ($urandom_range(9) < 4)
        begin
            probe.func = FUNC_NEAREST;
            probe.ax   = x;
            probe.ay   = y;
            probe.az   = z;
            spot = plane_answer(probe);
            x = spot.near_x + coord_t'(jitter(100));
            y = spot.near_y + coord_t'(jitter(100));
            z = spot.near_z + coord_t'(jitter(100));
        end
    endfunction

    function automatic query_t random_query();
        query_t q;
        int     k;
        q.func = func_t'($urandom_range(3));
        random_vertex(q.ax, q.ay, q.az);
        random_vertex(q.bx, q.by, q.bz);
        random_vertex(q.cx, q.cy, q.cz);
        // near-parallel other plane: a scaled normal plus a small tilt
        if (q.func == FUNC_PLANE && $urandom_range(1) == 1)
        begin
            k = $urandom_range(1, 3);
            q.ax = coord_t'(norm_x * k + jitter(1500));
            q.ay = coord_t'(norm_y * k + jitter(1500));
            q.az = coord_t'(norm_z * k + jitter(1500));
        end
        return q;
    endfunction

    task automatic queue_query(func_t f, coord_t x0, coord_t y0, coord_t z0,
                               coord_t x1 = '0, coord_t y1 = '0, coord_t z1 = '0,
                               coord_t x2 = '0, coord_t y2 = '0, coord_t z2 = '0);
        query_t q;
        q.func = f;
        q.ax = x0;
        q.ay = y0;
        q.az = z0;
        q.bx = x1;
        q.by = y1;
        q.bz = z1;
        q.cx = x2;
        q.cy = y2;
        q.cz = z2;
        query_backlog.push_back(q);
    endtask

    // ------------------------------------------------------------------
    // configuration writes, only issued while nothing is in flight
    // ------------------------------------------------------------------
    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_WIDTH-1:0] value);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        // normals keep only their low bits, sign extended
        case (idx)
            REG_NORMAL_X:     norm_x    = longint'($signed(value[NORM_WIDTH-1:0]));
            REG_NORMAL_Y:     norm_y    = longint'($signed(value[NORM_WIDTH-1:0]));
            REG_NORMAL_Z:     norm_z    = longint'($signed(value[NORM_WIDTH-1:0]));
            REG_PLANE_OFFSET: plane_ofs = longint'($signed(value[OFFSET_WIDTH-1:0]));
            default:          ;
        endcase
    endtask

    task automatic set_plane(logic signed [NORM_WIDTH-1:0] nx,
                             logic signed [NORM_WIDTH-1:0] ny,
                             logic signed [NORM_WIDTH-1:0] nz,
                             logic [OFFSET_WIDTH-1:0] ofs);
        logic [31:0] fill;
        // unused upper data bits carry random junk
        fill = $urandom();
        write_reg(REG_NORMAL_X, {fill[31:NORM_WIDTH], nx});
        fill = $urandom();
        write_reg(REG_NORMAL_Y, {fill[31:NORM_WIDTH], ny});
        fill = $urandom();
        write_reg(REG_NORMAL_Z, {fill[31:NORM_WIDTH], nz});
        write_reg(REG_PLANE_OFFSET, ofs);
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // wait for every pending query to transfer and every result to arrive,
    // then let the pipeline drain a little further
    task automatic wait_idle();
        int guard;
        guard = 0;
        while ((query_backlog.size() != 0 || start || expected_answers.size() != 0)
               && guard < IDLE_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (LATENCY + 3) @(posedge clk);
    endtask

    // ------------------------------------------------------------------
    // clock
    // ------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // ------------------------------------------------------------------
    // driver: pops the backlog, holds start while busy, idles at random
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            start <= 1'b0;
        end
        else
        begin
            // command transfer at this edge: predict it against the
            // plane that is programmed now
            if (start && !busy)
                expected_answers.push_back(plane_answer(drive_q));
            // port free for the next query, or a random gap
            if (!start || !busy)
            begin
                if (query_backlog.size() != 0 && $urandom_range(99) >= idle_pct)
                begin
                    drive_q = query_backlog.pop_front();
                    start <= 1'b1;
                    func  <= drive_q.func;
                    ax    <= drive_q.ax;
                    ay    <= drive_q.ay;
                    az    <= drive_q.az;
                    bx    <= drive_q.bx;
                    by    <= drive_q.by;
                    bz    <= drive_q.bz;
                    cx    <= drive_q.cx;
                    cy    <= drive_q.cy;
                    cz    <= drive_q.cz;
                end
                else
                    start <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // monitor: every done pulse is a result transfer, compared with the
    // oldest expected answer
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_answers.size() == 0)
            begin
                if (mismatch_count < REPORT_LIMIT)
                    $display("[%0t] result transfer with no query pending", $realtime);
                mismatch_count++;
            end
            else
            begin
                want = expected_answers.pop_front();
                if (hit !== want.hit || near_x !== want.near_x || near_y !== want.near_y
                    || near_z !== want.near_z || first_distance !== want.distance)
                begin
                    if (mismatch_count < REPORT_LIMIT)
                        $display("[%0t] mismatch (expected/actual): hit %0b/%0b ",
                                 $realtime, want.hit, hit,
                                 "near_x %0d/%0d near_y %0d/%0d ",
                                 want.near_x, near_x, want.near_y, near_y,
                                 "near_z %0d/%0d distance %0d/%0d",
                                 want.near_z, near_z, want.distance, first_distance);
                    mismatch_count++;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // stimulus and end of run
    // ------------------------------------------------------------------
    initial
    begin
        int                           p;
        logic                  [31:0] pick;
        logic signed [NORM_WIDTH-1:0] nx, ny, nz;
        logic [OFFSET_WIDTH-1:0]      ofs;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // directed part on the reset plane z = 0, normal +z
        idle_pct = 30;
        // triangle: all on the plane, all above, straddling, one vertex
        // exactly on the plane, contact sum just under and just over the
        // threshold, all below, corner coordinates
        queue_query(FUNC_TRIANGLE, '0, '0, '0, '0, '0, '0, '0, '0, '0);
        queue_query(FUNC_TRIANGLE, '0, '0, ONE, ONE, '0, 2 * ONE, '0, ONE, ONE / 2);
        queue_query(FUNC_TRIANGLE, '0, '0, ONE, ONE, ONE, -ONE, -ONE, '0, ONE);
        queue_query(FUNC_TRIANGLE, ONE, ONE, '0, '0, '0, ONE, ONE, '0, ONE);
        queue_query(FUNC_TRIANGLE, '0, '0, 21, ONE, '0, 22, '0, ONE, 22);
        queue_query(FUNC_TRIANGLE, '0, '0, 22, ONE, '0, 22, '0, ONE, 22);
        queue_query(FUNC_TRIANGLE, '0, '0, -ONE, ONE, '0, -ONE, '0, ONE, -ONE);
        queue_query(FUNC_TRIANGLE, COORD_HI, COORD_HI, COORD_HI,
                    COORD_LO, COORD_LO, COORD_LO, '0, '0, '0);
        // plane: parallel, perpendicular, tilt just under and just over
        // the parallel threshold, corner normal
        queue_query(FUNC_PLANE, '0, '0, ONE);
        queue_query(FUNC_PLANE, ONE, '0, '0);
        queue_query(FUNC_PLANE, 655, '0, ONE);
        queue_query(FUNC_PLANE, 656, '0, ONE);
        queue_query(FUNC_PLANE, COORD_HI, COORD_HI, COORD_LO);
        // point: either side of the contact threshold, corners
        queue_query(FUNC_POINT, ONE, -ONE, 65);
        queue_query(FUNC_POINT, ONE, -ONE, 66);
        queue_query(FUNC_POINT, '0, '0, -65);
        queue_query(FUNC_POINT, COORD_LO, COORD_LO, COORD_LO);
        queue_query(FUNC_POINT, COORD_HI, COORD_HI, COORD_HI);
        // nearest point with saturating coordinates
        queue_query(FUNC_NEAREST, COORD_HI, COORD_HI, COORD_HI);
        queue_query(FUNC_NEAREST, COORD_LO, COORD_LO, COORD_LO);
        queue_query(FUNC_NEAREST, 1, -1, 12345);

        // random phases, each under its own plane; sender gaps 30%, then
        // 71%, then back to back
        for (p = 0; p < PHASES; p++)
        begin
            wait_idle();
            idle_pct = (p < PHASES / 3) ? 30 : ((p < 2 * PHASES / 3) ? 71 : 0);
            case (p)
                0:
                begin
                    nx = 18'sd65536;  ny = '0; nz = '0; ofs = 32'h7FFF_FFFF;
                end
                1:
                begin
                    nx = '0; ny = -18'sd65536; nz = '0; ofs = 32'h8000_0000;
                end
                2:
                begin
                    // patterns outside the unit range
                    nx = 18'sd131071; ny = -18'sd131072; nz = 18'sd131071;
                    ofs = $urandom();
                end
                3:
                begin
                    nx = 18'sd46341; ny = '0; nz = -18'sd46341;
                    ofs = 32'(jitter(1 << 20));
                end
                default:
                begin
                    pick = $urandom();
                    case (pick[1:0])
                        2'd0:
                        begin
                            nx = '0; ny = '0; nz = '0;
                            case (pick[3:2])
                                2'd0: nx = pick[4] ? -18'sd65536 : 18'sd65536;
                                2'd1: ny = pick[4] ? -18'sd65536 : 18'sd65536;
                                default: nz = pick[4] ? -18'sd65536 : 18'sd65536;
                            endcase
                        end
                        2'd1:
                        begin
                            nx = 18'($urandom());
                            ny = 18'($urandom());
                            nz = 18'($urandom());
                        end
                        2'd2:
                        begin
                            nx = 18'(jitter(46341));
                            ny = 18'(jitter(46341));
                            nz = 18'(jitter(46341));
                        end
                        default:
                        begin
                            nx = pick[8] ? -18'sd65536 : 18'sd65536;
                            ny = pick[9] ? -18'sd65536 : 18'sd65536;
                            nz = pick[10] ? -18'sd65536 : 18'sd65536;
                        end
                    endcase
                    case (pick[13:12])
                        2'd0: ofs = '0;
                        2'd1: ofs = 32'(jitter(1 << 20));
                        2'd2: ofs = $urandom();
                        default: ofs = pick[14] ? 32'h7FFF_FFFF : 32'h8000_0000;
                    endcase
                end
            endcase
            set_plane(nx, ny, nz, ofs);
            repeat (PHASE_ITEMS) query_backlog.push_back(random_query());
        end

        wait_idle();
        // answers still owed at the end are failures too
        mismatch_count += expected_answers.size();
        if (mismatch_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // hard stop far beyond the slowest correct run
    initial
    begin
        #(TIMEOUT_NS);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: plane_query_unit_top.f
+incdir+hdl
hdl/pqu_pkg.sv
hdl/pqu_dist_lane.sv
hdl/pqu_cross_lane.sv
hdl/pqu_proj_lane.sv
hdl/pqu_merge.sv
hdl/plane_query_unit_top.sv
sim/tb_plane_query_unit_top.sv
